// ===== src/cfla_pkg.sv =====
// Shared constants, codes and controller/datapath handshake types for the
// chunked free-list block allocator. No dependencies.
`default_nettype none

package cfla_pkg;

    // Field widths of requests, results and the configuration port.
    localparam int OP_W        = 1;
    localparam int CHUNK_W     = 2;
    localparam int BLOCK_W     = 8;
    localparam int STATUS_W    = 2;
    localparam int OFFSET_W    = 16;
    localparam int LINK_W      = 8;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 1;

    // Defaults for the top-level parameters.
    localparam int NUM_CHUNKS_DEF = 4;
    localparam int MAX_BLOCKS_DEF = 256;

    // Largest block size in bytes.
    localparam logic [CFG_DATA_W-1:0] SIZE_MAX = 9'd256;

    // Register indexes.
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_SIZE  = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_COUNT = 1'b1;

    // Register reset values.
    localparam logic [CFG_DATA_W-1:0] SIZE_RESET  = 9'd16;
    localparam logic [CFG_DATA_W-1:0] COUNT_RESET = 9'd256;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_BLOCK = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_FREE = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clear_en;
        logic accept;
        logic decide;
        logic finish;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic reinit;
        logic clear_last;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

// ===== src/cfla_if.sv =====
// Request and result channel interfaces with valid/ready handshake.
// Depends on cfla_pkg for the payload widths.
`default_nettype none

interface cfla_req_if;
    logic                          valid;
    logic                          ready;
    logic [cfla_pkg::OP_W-1:0]     operation;
    logic [cfla_pkg::CHUNK_W-1:0]  chunk_index;
    logic [cfla_pkg::BLOCK_W-1:0]  block_index;

    modport source (output valid, output operation, output chunk_index,
                    output block_index, input ready);
    modport sink   (input valid, input operation, input chunk_index,
                    input block_index, output ready);
endinterface

interface cfla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [cfla_pkg::STATUS_W-1:0] status;
    logic [cfla_pkg::CHUNK_W-1:0]  out_chunk;
    logic [cfla_pkg::BLOCK_W-1:0]  out_block;
    logic [cfla_pkg::OFFSET_W-1:0] byte_offset;

    modport source (output valid, output status, output out_chunk,
                    output out_block, output byte_offset, input ready);
    modport sink   (input valid, input status, input out_chunk,
                    input out_block, input byte_offset, output ready);
endinterface

`default_nettype wire

// ===== src/chunked_free_list_block_allocator_core.sv =====
// Top level of the chunked free-list block allocator: controller plus
// datapath. Depends on cfla_pkg, cfla_if, cfla_ctrl and cfla_dpath.
`default_nettype none

// Fixed-size block allocator over NUM_CHUNKS chunks of up to MAX_BLOCKS
// blocks, each chunk keeping a free list in an on-chip link memory. After
// reset, and again after every write of block_count, the link memory is
// initialized by a sweep over all NUM_CHUNKS * 2**ceil(log2(MAX_BLOCKS))
// entries (1024 at the defaults) during which no request is taken;
// configuration writes are still taken. Every request, allocate or free,
// reaches the output register through these steps: a decide step that picks
// the chunk and reads or writes the link memory, a step that applies the
// read link and forms the byte offset in the multiplier, and the output
// load. The next request is accepted in the cycle after that load, so a
// request is not taken while the previous one is still in these steps, as
// set by the controller's step sequence. A finished result waits in the
// output register without blocking acceptance of the next request.
module chunked_free_list_block_allocator_core #(
    parameter int NUM_CHUNKS = cfla_pkg::NUM_CHUNKS_DEF,
    parameter int MAX_BLOCKS = cfla_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [cfla_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [cfla_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    cfla_req_if.sink                              req,
    cfla_rsp_if.source                            rsp
);

    cfla_pkg::cmd_t  cmd;
    cfla_pkg::stat_t stat;

    cfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    cfla_dpath #(
        .NUM_CHUNKS (NUM_CHUNKS),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dpath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .operation   (req.operation),
        .chunk_index (req.chunk_index),
        .block_index (req.block_index),
        .rsp_valid   (rsp.valid),
        .rsp_ready   (rsp.ready),
        .status      (rsp.status),
        .out_chunk   (rsp.out_chunk),
        .out_block   (rsp.out_block),
        .byte_offset (rsp.byte_offset),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

`default_nettype wire

// ===== src/cfla_ctrl.sv =====
// Sequencing controller of the allocator: link memory sweep, request
// acceptance and the per-request step sequence. Depends on cfla_pkg.
`default_nettype none

module cfla_ctrl (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           req_valid,
    output logic                req_ready,
    input  wire cfla_pkg::stat_t stat,
    output cfla_pkg::cmd_t      cmd
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DECIDE = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // A block_count write holds off requests in the same cycle, so the
    // request is taken against the reinitialized state.
    assign req_ready = (state_reg == ST_IDLE) && !stat.reinit;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.finish = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
        if (stat.reinit)
        begin
            state_next = ST_CLEAR;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_accept_to_decide: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == ST_DECIDE))
        else $error("accepted request did not move to the decide step");

    a_load_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> stat.out_free)
        else $error("result loaded while the output register is occupied");

    a_reinit_clears: assert property (@(posedge clk) disable iff (!rst_n)
        stat.reinit |=> (state_reg == ST_CLEAR))
        else $error("block_count write did not start a link memory sweep");

endmodule

`default_nettype wire

// ===== src/cfla_dpath.sv =====
// Datapath of the allocator: configuration registers, chunk heads and
// counts, the link memory, offset multiplier and output register.
// Depends on cfla_pkg.
`default_nettype none

module cfla_dpath #(
    parameter int NUM_CHUNKS = cfla_pkg::NUM_CHUNKS_DEF,
    parameter int MAX_BLOCKS = cfla_pkg::MAX_BLOCKS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_wr_en,
    input  wire logic [cfla_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [cfla_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  wire logic [cfla_pkg::OP_W-1:0]          operation,
    input  wire logic [cfla_pkg::CHUNK_W-1:0]       chunk_index,
    input  wire logic [cfla_pkg::BLOCK_W-1:0]       block_index,
    output logic                                    rsp_valid,
    input  wire logic                               rsp_ready,
    output logic [cfla_pkg::STATUS_W-1:0]           status,
    output logic [cfla_pkg::CHUNK_W-1:0]            out_chunk,
    output logic [cfla_pkg::BLOCK_W-1:0]            out_block,
    output logic [cfla_pkg::OFFSET_W-1:0]           byte_offset,
    input  wire cfla_pkg::cmd_t                     cmd,
    output cfla_pkg::stat_t                         stat
);

    localparam int CW    = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
    localparam int BW    = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam int AW    = CW + BW;
    localparam int DEPTH = NUM_CHUNKS * (2 ** BW);
    localparam int DW    = cfla_pkg::CFG_DATA_W;

    // Clamp a raw block_count value into 1 .. MAX_BLOCKS.
    function automatic logic [DW-1:0] clamp_count(input logic [DW-1:0] v);
        logic [DW-1:0] r;
        if (v == '0)
        begin
            r = DW'(1);
        end
        else if (v > DW'(MAX_BLOCKS))
        begin
            r = DW'(MAX_BLOCKS);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // Configuration and chunk state.
    logic [DW-1:0]                      size_cfg_reg;
    logic [DW-1:0]                      count_cfg_reg;
    logic [cfla_pkg::CHUNK_W-1:0]       hint_reg;
    logic [cfla_pkg::LINK_W-1:0]        head_reg [NUM_CHUNKS];
    logic [CNT_W-1:0]                   cnt_reg  [NUM_CHUNKS];
    logic [AW-1:0]                      clr_cnt_reg;

    // Latched request and intermediate results.
    logic [cfla_pkg::OP_W-1:0]          op_reg;
    logic [cfla_pkg::CHUNK_W-1:0]       ch_in_reg;
    logic [cfla_pkg::BLOCK_W-1:0]       blk_in_reg;
    logic [cfla_pkg::STATUS_W-1:0]      res_status_reg;
    logic [cfla_pkg::CHUNK_W-1:0]       res_chunk_reg;
    logic [cfla_pkg::BLOCK_W-1:0]       res_block_reg;
    logic [CW-1:0]                      res_c_reg;
    logic                               res_alloc_reg;
    logic [cfla_pkg::OFFSET_W-1:0]      prod_reg;
    logic [cfla_pkg::LINK_W-1:0]        rd_data_reg;

    // Output register.
    logic                               out_valid_reg;
    logic [cfla_pkg::STATUS_W-1:0]      status_reg;
    logic [cfla_pkg::CHUNK_W-1:0]       out_chunk_reg;
    logic [cfla_pkg::BLOCK_W-1:0]       out_block_reg;
    logic [cfla_pkg::OFFSET_W-1:0]      byte_offset_reg;

    logic [cfla_pkg::LINK_W-1:0]        link_mem [DEPTH];

    logic [DW-1:0]                      eff_n;
    logic [DW-1:0]                      eff_size;
    logic [CW-1:0]                      hint_c;
    logic                               hint_has;
    logic                               scan_found;
    logic [CW-1:0]                      scan_c;
    logic [CW-1:0]                      alloc_c;
    logic                               alloc_ok;
    logic [cfla_pkg::LINK_W-1:0]        alloc_got;
    logic                               ch_ok;
    logic [CW-1:0]                      ch_c;
    logic [CNT_W-1:0]                   ch_cnt;
    logic                               free_ok;
    logic                               is_alloc;
    logic                               mem_we;
    logic [AW-1:0]                      mem_waddr;
    logic [cfla_pkg::LINK_W-1:0]        mem_wdata;
    logic                               mem_re;
    logic [AW-1:0]                      mem_raddr;
    logic [cfla_pkg::LINK_W-1:0]        clear_link;
    logic [2*DW-1:0]                    prod_full;

    assign stat.reinit     = cfg_wr_en && (cfg_index == cfla_pkg::REG_BLOCK_COUNT);
    assign stat.clear_last = (clr_cnt_reg == AW'(DEPTH - 1));
    assign stat.out_free   = !out_valid_reg || rsp_ready;

    assign eff_n = clamp_count(count_cfg_reg);

    always_comb
    begin
        if (size_cfg_reg == '0)
        begin
            eff_size = DW'(1);
        end
        else if (size_cfg_reg > cfla_pkg::SIZE_MAX)
        begin
            eff_size = cfla_pkg::SIZE_MAX;
        end
        else
        begin
            eff_size = size_cfg_reg;
        end
    end

    // Allocation: the hinted chunk, or else the lowest chunk with a free block.
    assign hint_c   = CW'(hint_reg);
    assign hint_has = (cnt_reg[hint_c] != '0);

    always_comb
    begin
        scan_found = 1'b0;
        scan_c     = '0;
        for (int i = NUM_CHUNKS - 1; i >= 0; i--)
        begin
            if (cnt_reg[i] != '0)
            begin
                scan_found = 1'b1;
                scan_c     = CW'(i);
            end
        end
    end

    assign alloc_c   = hint_has ? hint_c : scan_c;
    assign alloc_ok  = hint_has || scan_found;
    assign alloc_got = head_reg[alloc_c];
    assign is_alloc  = (op_reg == cfla_pkg::OP_ALLOC);

    // Free checks. The chunk count is looked up by match, since the request
    // may name a chunk that does not exist.
    assign ch_ok = (32'(ch_in_reg) < NUM_CHUNKS);
    assign ch_c  = CW'(ch_in_reg);

    always_comb
    begin
        ch_cnt = '0;
        for (int i = 0; i < NUM_CHUNKS; i++)
        begin
            if (32'(ch_in_reg) == i)
            begin
                ch_cnt = cnt_reg[i];
            end
        end
    end

    assign free_ok = ch_ok && (DW'(blk_in_reg) < eff_n) && (DW'(ch_cnt) < eff_n);

    // Link memory port control.
    assign clear_link = cfla_pkg::LINK_W'(32'(clr_cnt_reg[BW-1:0]) + 1);
    assign mem_we     = cmd.clear_en || (cmd.decide && !is_alloc && free_ok);
    assign mem_waddr  = cmd.clear_en ? clr_cnt_reg : {ch_c, blk_in_reg[BW-1:0]};
    assign mem_wdata  = cmd.clear_en ? clear_link : head_reg[ch_c];
    assign mem_re     = cmd.decide && is_alloc && alloc_ok;
    assign mem_raddr  = {alloc_c, alloc_got[BW-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= link_mem[mem_raddr];
        end
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_cfg_reg  <= cfla_pkg::SIZE_RESET;
            count_cfg_reg <= cfla_pkg::COUNT_RESET;
        end
        else if (cfg_wr_en)
        begin
            if (cfg_index == cfla_pkg::REG_BLOCK_SIZE)
            begin
                size_cfg_reg <= cfg_wdata;
            end
            else if (cfg_index == cfla_pkg::REG_BLOCK_COUNT)
            begin
                count_cfg_reg <= cfg_wdata;
            end
        end
    end

    // Chunk heads, counts, hint and the sweep counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hint_reg      <= '0;
            clr_cnt_reg   <= '0;
            res_alloc_reg <= 1'b0;
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= CNT_W'(MAX_BLOCKS);
            end
        end
        else if (stat.reinit)
        begin
            hint_reg      <= '0;
            clr_cnt_reg   <= '0;
            res_alloc_reg <= 1'b0;
            for (int i = 0; i < NUM_CHUNKS; i++)
            begin
                head_reg[i] <= '0;
                cnt_reg[i]  <= CNT_W'(clamp_count(cfg_wdata));
            end
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
            end
            if (cmd.decide)
            begin
                res_alloc_reg <= is_alloc && alloc_ok;
                if (is_alloc && alloc_ok && !hint_has)
                begin
                    hint_reg <= cfla_pkg::CHUNK_W'(alloc_c);
                end
                if (!is_alloc && free_ok)
                begin
                    head_reg[ch_c] <= blk_in_reg;
                    cnt_reg[ch_c]  <= cnt_reg[ch_c] + CNT_W'(1);
                end
            end
            // The popped block's link arrives from memory one step later.
            if (cmd.finish && res_alloc_reg)
            begin
                head_reg[res_c_reg] <= rd_data_reg;
                cnt_reg[res_c_reg]  <= cnt_reg[res_c_reg] - CNT_W'(1);
            end
        end
    end

    assign prod_full = (2*DW)'(res_block_reg) * (2*DW)'(eff_size);

    // Request capture and result formation.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg     <= operation;
            ch_in_reg  <= chunk_index;
            blk_in_reg <= block_index;
        end
        if (cmd.decide)
        begin
            res_c_reg <= is_alloc ? alloc_c : ch_c;
            if (is_alloc)
            begin
                if (alloc_ok)
                begin
                    res_status_reg <= cfla_pkg::STATUS_OK;
                    res_chunk_reg  <= cfla_pkg::CHUNK_W'(alloc_c);
                    res_block_reg  <= alloc_got;
                end
                else
                begin
                    res_status_reg <= cfla_pkg::STATUS_NO_BLOCK;
                    res_chunk_reg  <= '0;
                    res_block_reg  <= '0;
                end
            end
            else
            begin
                res_status_reg <= free_ok ? cfla_pkg::STATUS_OK : cfla_pkg::STATUS_BAD_FREE;
                res_chunk_reg  <= ch_in_reg;
                res_block_reg  <= blk_in_reg;
            end
        end
        if (cmd.finish)
        begin
            prod_reg <= (res_status_reg == cfla_pkg::STATUS_OK)
                        ? prod_full[cfla_pkg::OFFSET_W-1:0] : '0;
        end
        if (cmd.load_out)
        begin
            status_reg      <= res_status_reg;
            out_chunk_reg   <= res_chunk_reg;
            out_block_reg   <= res_block_reg;
            byte_offset_reg <= prod_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign rsp_valid   = out_valid_reg;
    assign status      = status_reg;
    assign out_chunk   = out_chunk_reg;
    assign out_block   = out_block_reg;
    assign byte_offset = byte_offset_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg[hint_c] <= CNT_W'(MAX_BLOCKS))
        else $error("free count of the hinted chunk exceeds the chunk size");

    a_sweep_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_en |-> (clr_cnt_reg <= AW'(DEPTH - 1)))
        else $error("link memory sweep ran past the last entry");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp_ready) |=> (out_valid_reg
            && $stable({status_reg, out_chunk_reg, out_block_reg, byte_offset_reg})))
        else $error("waiting result changed before it was taken");

endmodule

`default_nettype wire
